@@ design/lstwp_pkg.sv @@
// Package with shared types, constants and functions of the laser scan to world points unit.
package lstwp_pkg;

   localparam int MAX_BEAMS_DEFAULT  = 2048;
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS       = 24;
   localparam int STEP_BITS          = 5;
   localparam int DATA_BITS          = 56;
   localparam int NUM_REGS           = 6;
   localparam int ADDR_BITS          = 5;
   localparam int OUT_BITS           = 24;
   localparam int RANGE_BITS         = 16;
   localparam int INDEX_BITS         = 11;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QUEUE_PTR_BITS     = 2;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

   localparam logic [ADDR_BITS-1:0] REG_START  = 5'd0;
   localparam logic [ADDR_BITS-1:0] REG_STEP   = 5'd4;
   localparam logic [ADDR_BITS-1:0] REG_OFFY   = 5'd8;
   localparam logic [ADDR_BITS-1:0] REG_HEIGHT = 5'd12;
   localparam logic [ADDR_BITS-1:0] REG_ROLL   = 5'd16;
   localparam logic [ADDR_BITS-1:0] REG_YAW    = 5'd20;

   typedef enum logic {
      KIND_BEAM = 1'b0,
      KIND_POSE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [RANGE_BITS-1:0]    beam_range;
      logic                     last_beam;
      logic [31:0]              beam_a32;
      logic signed [23:0]       pose_x;
      logic signed [23:0]       pose_y;
      logic signed [15:0]       quat_z;
      logic signed [15:0]       quat_w;
   } job_type;

   typedef struct packed {
      logic [15:0]        start_angle;
      logic [15:0]        angle_step;
      logic signed [15:0] mount_offset_y;
      logic signed [15:0] mount_height;
      logic [15:0]        mount_roll;
      logic [15:0]        mount_yaw;
   } cfg_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_BITS-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

@@ design/lstwp_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface lstwp_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [10:0] beam_index;
   logic [15:0] beam_range;
   logic        last_beam;
   logic signed [23:0] pose_x;
   logic signed [23:0] pose_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   modport source (output valid, req_type, beam_index, beam_range, last_beam,
                   pose_x, pose_y, quat_z, quat_w, input ready);
   modport sink (input valid, req_type, beam_index, beam_range, last_beam,
                 pose_x, pose_y, quat_z, quat_w, output ready);
endinterface

interface lstwp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] world_x;
   logic signed [23:0] world_y;
   logic signed [23:0] world_z;
   logic        scan_end;
   modport source (output valid, world_x, world_y, world_z, scan_end, input ready);
   modport sink (input valid, world_x, world_y, world_z, scan_end, output ready);
endinterface

@@ design/lstwp_front.sv @@
// Front end: accepts words, drops out-of-range beams and forms the beam angle.
module lstwp_front
   import lstwp_pkg::*;
#(
   parameter int MAX_BEAMS  = MAX_BEAMS_DEFAULT,
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   lstwp_req_if.sink req,
   input  cfg_type cfg,
   output logic    job_valid,
   output job_type job,
   input  logic    job_ready
);

   localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = '1;

   logic        job_valid_ff, job_valid_in;
   job_type     job_ff, job_in;
   logic [26:0] prod;
   logic [ANGLE_BITS-1:0] ang;
   logic        keep;

   assign req.ready = !job_valid_ff || job_ready;
   assign prod = 27'(req.beam_index) * 27'(cfg.angle_step);
   assign ang = ANGLE_BITS'(32'(cfg.start_angle) + 32'(prod)) & ANGLE_MASK;
   assign keep = (req.req_type == KIND_POSE) || (32'(req.beam_index) < 32'(MAX_BEAMS));

   always_comb begin
      job_in.kind       = kind_type'(req.req_type);
      job_in.beam_range = req.beam_range;
      job_in.last_beam  = req.last_beam;
      job_in.beam_a32   = 32'({ang, {(32-ANGLE_BITS){1'b0}}});
      job_in.pose_x     = req.pose_x;
      job_in.pose_y     = req.pose_y;
      job_in.quat_z     = req.quat_z;
      job_in.quat_w     = req.quat_w;
      job_valid_in      = job_valid_ff && !job_ready;
      if (req.valid && req.ready && keep) begin
         job_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      if (req.valid && req.ready) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job = job_ff;

endmodule

@@ design/lstwp_queue.sv @@
// Short job queue between front end and back end.
module lstwp_queue
   import lstwp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   output logic    in_ready,
   output logic    out_valid,
   output job_type out_job,
   input  logic    out_ready
);

   job_type mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_BITS:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff + QUEUE_PTR_BITS'(push);
      rd_in  = rd_ff + QUEUE_PTR_BITS'(pop);
      cnt_in = cnt_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= in_job;
      end
   end

endmodule

@@ design/lstwp_back.sv @@
// Back end: shared CORDIC sequencer for the heading and the point transform chain.
module lstwp_back
   import lstwp_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_ready,
   lstwp_rsp_if.source rsp
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_ITER  = 7'b0000100,
      ST_GAINX = 7'b0001000,
      ST_GAINY = 7'b0010000,
      ST_NEXT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = '1;

   state_type state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic signed [DATA_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic signed [DATA_BITS-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [DATA_BITS-1:0] gx_ff, gx_in;
   logic signed [DATA_BITS-1:0] mop_full;
   logic signed [31:0] mop;
   logic signed [63:0] mul;
   logic signed [DATA_BITS-1:0] rnd;
   logic signed [23:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [ANGLE_BITS-1:0] head_ff, head_in;
   logic signed [23:0] npx_ff, npx_in, npy_ff, npy_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic signed [DATA_BITS-1:0] dx, dy, sx, sy;
   logic [31:0] atab;
   logic vec_mode;
   logic [31:0] rot_a32;
   logic [1:0] quad;
   logic [31:0] resid;
   logic signed [DATA_BITS-1:0] ix, iy;
   logic [31:0] hneg;

   // Phases: 0 beam angle, 1 heading, 2 roll, 3 yaw, 4 atan2 for a pose.
   localparam logic [2:0] PH_BEAM = 3'd0;
   localparam logic [2:0] PH_HEAD = 3'd1;
   localparam logic [2:0] PH_ROLL = 3'd2;
   localparam logic [2:0] PH_YAW  = 3'd3;
   localparam logic [2:0] PH_ATAN = 3'd4;

   function automatic logic signed [23:0] sat(input logic signed [DATA_BITS-1:0] v);
      logic signed [23:0] r;
      if (v > DATA_BITS'(64'sd8388607)) begin
         r = 24'sd8388607;
      end else if (v < -DATA_BITS'(64'sd8388608)) begin
         r = -24'sd8388608;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   assign job_ready = (state_ff == ST_IDLE);
   assign vec_mode  = (phase_ff == PH_ATAN);
   assign atab = atan_entry(step_ff);
   assign sx = cx_ff >>> step_ff;
   assign sy = cy_ff >>> step_ff;
   assign dx = sy;
   assign dy = sx;
   // Rotated vectors stay well inside 32 signed bits before the gain multiply.
   assign mop_full = (state_ff == ST_GAINX) ? cx_ff : cy_ff;
   assign mop = mop_full[31:0];
   assign mul = mop * GAIN_Q30;
   assign rnd = DATA_BITS'((mul + (64'sd1 <<< 33)) >>> 34);

   always_comb begin
      unique case (phase_ff)
         PH_BEAM: rot_a32 = cz_ff[31:0];
         PH_HEAD: rot_a32 = 32'({head_ff, {(32-ANGLE_BITS){1'b0}}});
         PH_ROLL: rot_a32 = 32'({ANGLE_BITS'(cfg.mount_roll) & ANGLE_MASK,
                                 {(32-ANGLE_BITS){1'b0}}});
         PH_YAW:  rot_a32 = 32'({ANGLE_BITS'(cfg.mount_yaw) & ANGLE_MASK,
                                 {(32-ANGLE_BITS){1'b0}}});
         default: rot_a32 = '0;
      endcase
   end

   always_comb begin
      quad  = 2'((rot_a32 + 32'h20000000) >> 30);
      resid = rot_a32 - {quad, 30'd0};
      unique case (phase_ff)
         PH_ROLL: begin ix = py_ff; iy = pz_ff; end
         default: begin ix = px_ff; iy = py_ff; end
      endcase
   end

   assign hneg = 32'd0 - {cz_ff[30:0], 1'b0};

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; step_in = step_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff; gx_in = gx_ff;
      pose_x_in = pose_x_ff; pose_y_in = pose_y_ff; head_in = head_ff;
      npx_in = npx_ff; npy_in = npy_ff; last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               last_in = job.last_beam;
               if (job.kind == KIND_POSE) begin
                  npx_in = job.pose_x;
                  npy_in = job.pose_y;
                  phase_in = PH_ATAN;
                  cx_in = DATA_BITS'(job.quat_w);
                  cy_in = DATA_BITS'(job.quat_z);
               end else begin
                  phase_in = PH_BEAM;
                  px_in = DATA_BITS'({1'b0, job.beam_range});
                  py_in = '0;
                  cz_in = 34'(job.beam_a32);
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_in = '0;
            if (vec_mode) begin
               if (cx_ff == '0 && cy_ff == '0) begin
                  cz_in = '0;
                  state_in = ST_NEXT;
               end else if (cx_ff < 0) begin
                  cx_in = (-cx_ff) <<< 8; cy_in = (-cy_ff) <<< 8;
                  cz_in = 34'sd1 <<< 31;
                  state_in = ST_ITER;
               end else begin
                  cx_in = cx_ff <<< 8; cy_in = cy_ff <<< 8;
                  cz_in = '0;
                  state_in = ST_ITER;
               end
            end else begin
               cz_in = 34'(signed'(resid));
               unique case (quad)
                  2'd1: begin cx_in = -iy; cy_in = ix; end
                  2'd2: begin cx_in = -ix; cy_in = -iy; end
                  2'd3: begin cx_in = iy; cy_in = -ix; end
                  default: begin cx_in = ix; cy_in = iy; end
               endcase
               cx_in = cx_in <<< 4;
               cy_in = cy_in <<< 4;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (vec_mode ? (cy_ff > 0) : (cz_ff >= 0)) begin
               cx_in = vec_mode ? cx_ff + dx : cx_ff - dx;
               cy_in = vec_mode ? cy_ff - dy : cy_ff + dy;
               cz_in = vec_mode ? cz_ff + 34'(atab) : cz_ff - 34'(atab);
            end else begin
               cx_in = vec_mode ? cx_ff - dx : cx_ff + dx;
               cy_in = vec_mode ? cy_ff + dy : cy_ff - dy;
               cz_in = vec_mode ? cz_ff - 34'(atab) : cz_ff + 34'(atab);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CORDIC_STEPS-1)) begin
               state_in = vec_mode ? ST_NEXT : ST_GAINX;
            end
         end
         ST_GAINX: begin
            gx_in = rnd;
            state_in = ST_GAINY;
         end
         ST_GAINY: begin
            state_in = ST_NEXT;
            unique case (phase_ff)
               PH_BEAM: begin px_in = gx_ff; py_in = rnd; phase_in = PH_HEAD; end
               PH_HEAD: begin
                  px_in = gx_ff + DATA_BITS'(pose_y_ff);
                  py_in = rnd + DATA_BITS'(pose_x_ff) + DATA_BITS'(cfg.mount_offset_y);
                  pz_in = -DATA_BITS'(cfg.mount_height);
                  phase_in = PH_ROLL;
               end
               PH_ROLL: begin py_in = gx_ff; pz_in = rnd; phase_in = PH_YAW; end
               default: begin px_in = gx_ff; py_in = rnd; state_in = ST_OUT; end
            endcase
         end
         ST_NEXT: begin
            if (vec_mode) begin
               pose_x_in = npx_ff;
               pose_y_in = npy_ff;
               head_in = ANGLE_BITS'((33'(hneg) + (33'd1 << (31 - ANGLE_BITS)))
                                     >> (32 - ANGLE_BITS)) & ANGLE_MASK;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               ox_in = sat(px_ff); oy_in = sat(py_ff); oz_in = sat(pz_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         head_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         head_ff <= head_in;
      end
      phase_ff <= phase_in; step_ff <= step_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in; gx_ff <= gx_in;
      npx_ff <= npx_in; npy_ff <= npy_in; last_ff <= last_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
   end

   logic scan_end_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) begin
         scan_end_ff <= last_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.world_x  = ox_ff;
   assign rsp.world_y  = oy_ff;
   assign rsp.world_z  = oz_ff;
   assign rsp.scan_end = scan_end_ff;

endmodule

@@ design/laser_scan_to_world_points_unit.sv @@
// Top level of the laser scan to world points unit.
// Usage:
// The request channel takes beam words (req_type 0) and pose words (req_type 1).
// A pose word stores the position and a heading from the quaternion and makes no result.
// A beam word gives one result word on the response channel with the world point.
// Beams whose index is not below MAX_BEAMS are dropped in the front end.
// The front end registers and classifies a word, then a four-entry queue
// holds it for the back end.
// The back end runs one shared 24-step CORDIC unit: a beam takes four rotations
// (beam angle, heading, roll and yaw) one after another; a pose takes one
// vectoring run that forms its heading.
// That shared CORDIC unit sets the rate: a new word starts only once the last is done.
// The result sits in an output register, so the back end starts the next word
// while a result waits; when the receiver stalls, the queue fills and then
// the request ready drops.
// Reset clears the control state, the configuration and the stored pose to zero.
// The user must write csr_ configuration only while idle; the unit does not check this.
module laser_scan_to_world_points_unit
   import lstwp_pkg::*;
#(
   parameter int MAX_BEAMS  = MAX_BEAMS_DEFAULT,
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   lstwp_req_if.sink   req,
   lstwp_rsp_if.source rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   cfg_type cfg_ff, cfg_in;
   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            REG_START:  cfg_in.start_angle    = csr_pwdata[15:0];
            REG_STEP:   cfg_in.angle_step     = csr_pwdata[15:0];
            REG_OFFY:   cfg_in.mount_offset_y = csr_pwdata[15:0];
            REG_HEIGHT: cfg_in.mount_height   = csr_pwdata[15:0];
            REG_ROLL:   cfg_in.mount_roll     = csr_pwdata[15:0];
            REG_YAW:    cfg_in.mount_yaw      = csr_pwdata[15:0];
            default: ;
         endcase
      end
      unique case (csr_paddr)
         REG_START:  csr_prdata = 32'(cfg_ff.start_angle);
         REG_STEP:   csr_prdata = 32'(cfg_ff.angle_step);
         REG_OFFY:   csr_prdata = 32'(cfg_ff.mount_offset_y);
         REG_HEIGHT: csr_prdata = 32'(cfg_ff.mount_height);
         REG_ROLL:   csr_prdata = 32'(cfg_ff.mount_roll);
         REG_YAW:    csr_prdata = 32'(cfg_ff.mount_yaw);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lstwp_front #(.MAX_BEAMS(MAX_BEAMS), .ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock, .reset, .req, .cfg(cfg_ff),
      .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
   );

   lstwp_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_job(fj), .in_ready(fj_ready),
      .out_valid(bj_valid), .out_job(bj), .out_ready(bj_ready)
   );

   lstwp_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff),
      .job_valid(bj_valid), .job(bj), .job_ready(bj_ready), .rsp
   );

endmodule

@@ design/lstwp_checker.sv @@
// Port-level checker for the laser scan to world points unit, with its bind.
module lstwp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [23:0] rsp_world_x,
   input logic csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_world_x))
      else $error("result word changed while stalled");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready)
      else $error("request ready low after reset");

endmodule

bind laser_scan_to_world_points_unit lstwp_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_world_x(rsp.world_x),
   .csr_pready(csr_pready)
);
